FILE: hw/rtl/nses_pkg.sv
package nses_pkg;

   // Field widths fixed by the transaction formats
   localparam int KIND_W     = 1;
   localparam int IDX_W      = 10;
   localparam int VAL_W      = 48;
   localparam int STATUS_W   = 2;
   localparam int CNT_W      = 11;
   localparam int TOL_W      = 47;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 48;

   // Default table size
   localparam int TABLE_DEPTH_DEF = 1024;

   typedef enum logic [KIND_W-1:0] {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_FAR   = 2'd1,
      STATUS_SMALL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_COUNT = 4'd0,
      CSR_TOLERANCE   = 4'd1
   } csr_reg_type;

endpackage

FILE: hw/rtl/nses_if.sv
// Request channel: table loads and search queries
interface nses_req_if;
   logic                                valid;
   logic                                ready;
   logic        [nses_pkg::KIND_W-1:0]  req_type;
   logic        [nses_pkg::IDX_W-1:0]   entry_index;
   logic signed [nses_pkg::VAL_W-1:0]   value;

   modport source (output valid, req_type, entry_index, value, input ready);
   modport sink   (input valid, req_type, entry_index, value, output ready);
endinterface

// Response channel: one transaction per query
interface nses_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [nses_pkg::STATUS_W-1:0] status;
   logic        [nses_pkg::IDX_W-1:0]    found_index;
   logic signed [nses_pkg::VAL_W-1:0]    found_value;

   modport source (output valid, status, found_index, found_value, input ready);
   modport sink   (input valid, status, found_index, found_value, output ready);
endinterface

// Register write channel
interface nses_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [nses_pkg::CSR_IDX_W-1:0]        index;
   logic [nses_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/nearest_sorted_entry_search.sv
// Nearest-entry search over a monotonic (ascending or descending) table.
//
// req : load transactions (req_type 0) write value at entry_index and give no
//       response; query transactions (req_type 1) bisect the first entry_count
//       entries and return one rsp transaction: status found, beyond
//       tolerance, or fewer than two entries. Loads past the table end drop.
// csr : index 0 entry_count, index 1 tolerance; other indexes are ignored.
//       Write only while no query is in flight.
// Sequence: a load is written to the table in the cycle it is accepted. A query
//       reads the first and the last entry, then does one table read per
//       bisection step on the single read port, then passes a distance stage
//       and a pick stage to a registered response. Fewer than two entries skip
//       the reads and go straight to the pick stage.
// Throughput: one query at a time; req is ready again in the cycle the
//       response appears, so the next transaction overlaps its delivery.
// Stall: a held response stalls the next query in its pick stage; req stays not ready meanwhile.
// Reset: synchronous; req and csr are not ready, the registers clear to zero
//       and a pending response drops. Table contents are undefined until loaded.
module nearest_sorted_entry_search #(
   parameter int TABLE_DEPTH = nses_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nses_req_if.sink    req,
   nses_rsp_if.source  rsp,
   nses_csr_if.sink    csr
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic                               tbl_wr_en;
   logic        [AW-1:0]               tbl_wr_addr;
   logic signed [nses_pkg::VAL_W-1:0]  tbl_wr_data;
   logic                               tbl_rd_en;
   logic        [AW-1:0]               tbl_rd_addr;
   logic signed [nses_pkg::VAL_W-1:0]  tbl_rd_data;

   nses_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr         (csr),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data)
   );

   nses_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

FILE: hw/rtl/nses_table.sv
module nses_table #(
   parameter int TABLE_DEPTH = nses_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic        [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   input  logic signed [nses_pkg::VAL_W-1:0]        wr_data,
   input  logic                                     rd_en,
   input  logic        [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   output logic signed [nses_pkg::VAL_W-1:0]        rd_data
);

   logic signed [nses_pkg::VAL_W-1:0] coord_mem_ff [TABLE_DEPTH];
   logic signed [nses_pkg::VAL_W-1:0] rd_data_ff;

   // Write one entry per load
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= coord_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nses_search.sv
module nses_search #(
   parameter int TABLE_DEPTH = nses_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   nses_req_if.sink                                 req,
   nses_rsp_if.source                               rsp,
   nses_csr_if.sink                                 csr,
   output logic                                     tbl_wr_en,
   output logic        [$clog2(TABLE_DEPTH)-1:0]    tbl_wr_addr,
   output logic signed [nses_pkg::VAL_W-1:0]        tbl_wr_data,
   output logic                                     tbl_rd_en,
   output logic        [$clog2(TABLE_DEPTH)-1:0]    tbl_rd_addr,
   input  logic signed [nses_pkg::VAL_W-1:0]        tbl_rd_data
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int VW  = nses_pkg::VAL_W;
   localparam int DW  = VW + 1;
   localparam int NW0 = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = (nses_pkg::CNT_W > NW0) ? nses_pkg::CNT_W : NW0;
   localparam int PW  = (nses_pkg::IDX_W > AW) ? nses_pkg::IDX_W + 1 : AW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_FIRST,
      S_RD_LAST,
      S_DIR,
      S_STEP,
      S_DIST,
      S_PICK
   } state_type;

   // Magnitude of a difference of two table values
   function automatic logic [DW-1:0] abs_diff(input logic signed [VW-1:0] a,
                                              input logic signed [VW-1:0] b);
      logic signed [DW-1:0] d;
      d = DW'(a) - DW'(b);
      return d[DW-1] ? DW'(-d) : DW'(d);
   endfunction

   state_type                   state_ff, state_in;
   logic [nses_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [nses_pkg::TOL_W-1:0]  tol_ff, tol_in;
   logic signed [VW-1:0]        v_ff, v_in;
   logic [AW-1:0]               lo_ff, lo_in;
   logic [AW-1:0]               hi_ff, hi_in;
   logic [AW-1:0]               mid_ff, mid_in;
   logic signed [VW-1:0]        lo_val_ff, lo_val_in;
   logic signed [VW-1:0]        hi_val_ff, hi_val_in;
   logic                        asc_ff, asc_in;
   logic                        small_ff, small_in;
   logic [DW-1:0]               dlo_ff, dlo_in;
   logic [DW-1:0]               dhi_ff, dhi_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [nses_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [nses_pkg::IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic signed [VW-1:0]        rsp_value_ff, rsp_value_in;

   logic                        req_fire;
   logic                        out_free;
   logic [CW-1:0]               count_ext;
   logic [CW-1:0]               n_used;
   logic [AW-1:0]               n_last;
   logic                        go_lo;
   logic [AW-1:0]               lo_n, hi_n;
   logic [AW:0]                 pair_sum;
   logic [AW-1:0]               mid_n;
   logic [AW-1:0]               span_n;
   logic                        lo_wins;
   logic                        lo_ok, hi_ok;

   // Handshakes; accept nothing while reset is held
   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign csr.ready = !reset;
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Clamp the searched count to the table depth
   assign count_ext = CW'(count_ff);
   assign n_used    = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
   assign n_last    = AW'(n_used - CW'(1));

   // Load path straight into the table
   assign tbl_wr_en   = req_fire && (req.req_type == nses_pkg::REQ_LOAD) &&
                        (PW'(req.entry_index) < PW'(TABLE_DEPTH));
   assign tbl_wr_addr = AW'(req.entry_index);
   assign tbl_wr_data = req.value;

   // Narrow the bracket with the entry just read
   assign go_lo    = ((v_ff >= tbl_rd_data) == asc_ff);
   assign lo_n     = (state_ff == S_STEP && go_lo)  ? mid_ff : lo_ff;
   assign hi_n     = (state_ff == S_STEP && !go_lo) ? mid_ff : hi_ff;
   assign pair_sum = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_n    = AW'(pair_sum >> 1);
   assign span_n   = hi_n - lo_n;

   // Final choice between the two brackets
   assign lo_wins = (dlo_ff <= dhi_ff);
   assign lo_ok   = (dlo_ff <= DW'(tol_ff));
   assign hi_ok   = (dhi_ff <= DW'(tol_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tol_in        = tol_ff;
      v_in          = v_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      lo_val_in     = lo_val_ff;
      hi_val_in     = hi_val_ff;
      asc_in        = asc_ff;
      small_in      = small_ff;
      dlo_in        = dlo_ff;
      dhi_in        = dhi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = '0;

      // Register writes
      if (csr.valid && csr.ready) begin
         if (csr.index == nses_pkg::CSR_ENTRY_COUNT) begin
            count_in = csr.data[nses_pkg::CNT_W-1:0];
         end else if (csr.index == nses_pkg::CSR_TOLERANCE) begin
            tol_in = csr.data[nses_pkg::TOL_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req.req_type == nses_pkg::REQ_QUERY) begin
               v_in     = req.value;
               lo_in    = '0;
               hi_in    = n_last;
               small_in = (count_ff < nses_pkg::CNT_W'(2));
               state_in = (count_ff < nses_pkg::CNT_W'(2)) ? S_PICK : S_RD_FIRST;
            end
         end
         S_RD_FIRST: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = '0;
            state_in    = S_RD_LAST;
         end
         S_RD_LAST: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = hi_ff;
            lo_val_in   = tbl_rd_data;
            state_in    = S_DIR;
         end
         S_DIR, S_STEP: begin
            // Direction is settled once the last entry arrives
            if (state_ff == S_DIR) begin
               hi_val_in = tbl_rd_data;
               asc_in    = (tbl_rd_data >= lo_val_ff);
            end else begin
               lo_in = lo_n;
               hi_in = hi_n;
               if (go_lo) begin
                  lo_val_in = tbl_rd_data;
               end else begin
                  hi_val_in = tbl_rd_data;
               end
            end
            if (span_n > AW'(1)) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = mid_n;
               mid_in      = mid_n;
               state_in    = S_STEP;
            end else begin
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            dlo_in   = abs_diff(lo_val_ff, v_ff);
            dhi_in   = abs_diff(hi_val_ff, v_ff);
            state_in = S_PICK;
         end
         S_PICK: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (small_ff) begin
                  rsp_status_in = nses_pkg::STATUS_SMALL;
                  rsp_index_in  = '0;
                  rsp_value_in  = '0;
               end else if (lo_wins ? lo_ok : hi_ok) begin
                  rsp_status_in = nses_pkg::STATUS_FOUND;
                  rsp_index_in  = nses_pkg::IDX_W'(lo_wins ? lo_ff : hi_ff);
                  rsp_value_in  = lo_wins ? lo_val_ff : hi_val_ff;
               end else begin
                  rsp_status_in = nses_pkg::STATUS_FAR;
                  rsp_index_in  = '0;
                  rsp_value_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff          <= v_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      lo_val_ff     <= lo_val_in;
      hi_val_ff     <= hi_val_in;
      asc_ff        <= asc_in;
      small_ff      <= small_in;
      dlo_ff        <= dlo_in;
      dhi_ff        <= dhi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_index = rsp_index_ff;
   assign rsp.found_value = rsp_value_ff;

   // A bisection step always works on a bracket wider than two neighbors
   a_step_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> (hi_ff - lo_ff) > AW'(1))
      else $error("bisection step on a collapsed bracket");

   // A new response only comes out of the pick stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_PICK))
      else $error("response raised outside the pick stage");

   // Miss and size-error responses carry zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != nses_pkg::STATUS_FOUND
         |-> rsp_index_ff == '0 && rsp_value_ff == '0)
      else $error("nonzero payload on a miss");

   // Table writes never overlap a search
   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> state_ff == S_IDLE && !tbl_rd_en)
      else $error("table write during a search");

endmodule

FILE: tb/sv/nearest_match_checker.sv
`timescale 1ns / 100ps

module nearest_match_checker #(
   parameter int DEPTH = nses_pkg::TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   nses_req_if  req,
   nses_rsp_if  rsp,
   nses_csr_if  csr,
   output int   fail_count,
   output int   outstanding,
   output int   found_count,
   output int   far_count,
   output int   small_count
);

   localparam int IDX_W = nses_pkg::IDX_W;
   localparam int VAL_W = nses_pkg::VAL_W;
   localparam int CNT_W = nses_pkg::CNT_W;
   localparam int TOL_W = nses_pkg::TOL_W;

   typedef struct {
      nses_pkg::status_type    status;
      logic [IDX_W-1:0]        idx;
      logic signed [VAL_W-1:0] coord;
   } match_type;

   // Private copy of the table and the two registers
   logic signed [VAL_W-1:0] coord_copy [DEPTH];
   logic [CNT_W-1:0]        cnt_reg = '0;
   logic [TOL_W-1:0]        tol_reg = '0;

   // Nearest matches owed by the block, oldest first
   match_type awaited_matches [$];

   int fails   = 0;
   int n_found = 0;
   int n_far   = 0;
   int n_small = 0;

   // Bisect the searched prefix, bracket the query, keep the nearer side
   function automatic match_type nearest_match(logic signed [VAL_W-1:0] q);
      int unsigned n, lo, hi, mid, best;
      bit          up;
      longint      qv, a, b, dlo, dhi, lim;
      match_type   m;
      m.status = nses_pkg::STATUS_SMALL;
      m.idx    = '0;
      m.coord  = '0;
      n = cnt_reg;
      if (n > DEPTH) n = DEPTH;
      if (n < 2) return m;
      up = coord_copy[n-1] >= coord_copy[0];
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if ((q >= coord_copy[mid]) == up) lo = mid;
         else hi = mid;
      end
      qv = q;
      a = coord_copy[lo];
      b = coord_copy[hi];
      dlo = (a >= qv) ? a - qv : qv - a;
      dhi = (b >= qv) ? b - qv : qv - b;
      // ties go to the lower index
      if (dlo <= dhi) begin
         best = lo;
      end else begin
         best = hi;
         dlo = dhi;
      end
      lim = tol_reg;
      if (dlo <= lim) begin
         m.status = nses_pkg::STATUS_FOUND;
         m.idx    = IDX_W'(best);
         m.coord  = coord_copy[best];
      end else begin
         m.status = nses_pkg::STATUS_FAR;
      end
      return m;
   endfunction

   // Track register writes, loads and queries; check every response
   always @(posedge clock) begin : watch
      match_type want;
      bit        bad;
      if (reset) begin
         cnt_reg = '0;
         tol_reg = '0;
         awaited_matches.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               nses_pkg::CSR_ENTRY_COUNT: cnt_reg = csr.data[CNT_W-1:0];
               nses_pkg::CSR_TOLERANCE:   tol_reg = csr.data[TOL_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.req_type == nses_pkg::REQ_LOAD) begin
               if (req.entry_index < DEPTH) coord_copy[req.entry_index] = req.value;
            end else begin
               awaited_matches.push_back(nearest_match(req.value));
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (awaited_matches.size() == 0) begin
               $display("%0t: response with nothing outstanding: status %0d index %0d value %0d",
                        $time, rsp.status, rsp.found_index, rsp.found_value);
               fails++;
            end else begin
               want = awaited_matches.pop_front();
               bad = 1'b0;
               if (rsp.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp.status);
                  bad = 1'b1;
               end
               if (rsp.found_index !== want.idx) begin
                  $display("%0t: found_index expected %0d actual %0d",
                           $time, want.idx, rsp.found_index);
                  bad = 1'b1;
               end
               if (rsp.found_value !== want.coord) begin
                  $display("%0t: found_value expected %0d actual %0d",
                           $time, want.coord, rsp.found_value);
                  bad = 1'b1;
               end
               if (bad) fails++;
               case (want.status)
                  nses_pkg::STATUS_FOUND: n_found++;
                  nses_pkg::STATUS_FAR:   n_far++;
                  default:                n_small++;
               endcase
            end
         end
      end
      fail_count  <= fails;
      outstanding <= awaited_matches.size();
      found_count <= n_found;
      far_count   <= n_far;
      small_count <= n_small;
   end

endmodule

FILE: tb/sv/nearest_sorted_entry_search_tb.sv
`timescale 1ns / 100ps

module nearest_sorted_entry_search_tb;

   localparam int     DEPTH            = nses_pkg::TABLE_DEPTH_DEF;
   localparam int     IDX_W            = nses_pkg::IDX_W;
   localparam int     VAL_W            = nses_pkg::VAL_W;
   localparam int     CNT_W            = nses_pkg::CNT_W;
   localparam int     CSR_IDX_W        = nses_pkg::CSR_IDX_W;
   localparam int     CSR_DATA_W       = nses_pkg::CSR_DATA_W;
   localparam int     RANDOM_ITEMS     = 150;
   localparam int     SETTLE_CYCLES    = 24;
   localparam int     LONG_HOLD_CYCLES = 300;
   localparam longint LIMIT_NS         = 64'd20_000_000;
   localparam longint VAL_MAX          = 64'sd140737488355327;
   localparam longint VAL_MIN          = -64'sd140737488355328;
   localparam logic [CSR_DATA_W-1:0] ALL_ONES = '1;

   logic clock;
   logic reset;

   nses_req_if req_ch ();
   nses_rsp_if rsp_ch ();
   nses_csr_if csr_ch ();

   int fail_count, outstanding, found_count, far_count, small_count;

   nearest_sorted_entry_search #(.TABLE_DEPTH(DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   nearest_match_checker #(.DEPTH(DEPTH)) match_mon (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .found_count (found_count),
      .far_count   (far_count),
      .small_count (small_count)
   );

   // Values loaded so far, used to aim queries at and between entries
   logic signed [VAL_W-1:0] shadow_table [DEPTH];
   int eff_count       = 0;
   bit quiet           = 1'b0;
   int hold_offs_asked = 0;
   int hold_offs       = 0;
   int loads_sent      = 0;
   int queries_sent    = 0;
   int settings_made   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint rand_upto(longint lim);
      logic [63:0] r;
      r = {$urandom, $urandom};
      r[63] = 1'b0;
      return longint'(r) % (lim + 1);
   endfunction

   function automatic logic [VAL_W-1:0] rand_bits48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[VAL_W-1:0];
   endfunction

   function automatic longint clamp_val(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   // Query coordinate: exact hits, midpoints, near misses, range ends, noise
   function automatic logic signed [VAL_W-1:0] pick_query();
      int     span, i;
      longint a, b, v;
      span = (eff_count < 2) ? 2 : eff_count;
      i = $urandom_range(0, span - 2);
      a = shadow_table[i];
      b = shadow_table[i+1];
      case ($urandom_range(0, 9))
         0, 1: v = shadow_table[$urandom_range(0, span - 1)];
         2, 3: v = (a + b) >>> 1;
         4, 5: v = clamp_val(a + rand_upto(262144) - 131072);
         6: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
         7: begin
            v = $urandom_range(0, 1) ? a : b;
            v = clamp_val($urandom_range(0, 1) ? v + rand_upto(64'sd1 <<< 40)
                                                : v - rand_upto(64'sd1 <<< 40));
         end
         default: v = $signed(rand_bits48());
      endcase
      return VAL_W'(v);
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic send_item(nses_pkg::req_kind_type kind, logic [IDX_W-1:0] idx,
                            logic signed [VAL_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.entry_index <= idx;
      req_ch.value       <= val;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == nses_pkg::REQ_LOAD) begin
         shadow_table[idx] = val;
         loads_sent++;
      end else begin
         queries_sent++;
      end
   endtask

   // Drop valid, wait for every response, then let a trailing load settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Reprogram both registers while idle, optionally poking an unused index
   task automatic program_regs(logic [CSR_DATA_W-1:0] cnt_word,
                               logic [CSR_DATA_W-1:0] tol_word, bit stray);
      int n;
      wait_idle();
      if (stray) csr_put(CSR_IDX_W'($urandom_range(2, 15)), rand_bits48());
      csr_put(nses_pkg::CSR_ENTRY_COUNT, cnt_word);
      csr_put(nses_pkg::CSR_TOLERANCE, tol_word);
      csr_ch.valid <= 1'b0;
      n = cnt_word[CNT_W-1:0];
      eff_count = (n > DEPTH) ? DEPTH : n;
      settings_made++;
   endtask

   // Load a monotonic run into entries 0..n-1: narrow steps, full range or flat
   task automatic fill_table(int n, bit descending, int shape);
      longint cur, step_max, step;
      int     i;
      case (shape)
         0: begin
            cur = rand_upto(64'sd1 <<< 47) - (64'sd1 <<< 46);
            step_max = 262144;
         end
         1: begin
            cur = VAL_MIN + rand_upto(1048576);
            step_max = (VAL_MAX - 1048576 - VAL_MIN) / (n - 1);
         end
         default: begin
            cur = $signed(rand_bits48());
            step_max = 0;
         end
      endcase
      for (i = 0; i < n; i++) begin
         send_item(nses_pkg::REQ_LOAD, descending ? IDX_W'(n - 1 - i) : IDX_W'(i),
                   VAL_W'(cur));
         step = ($urandom_range(0, 7) == 0) ? 0 : rand_upto(step_max);
         cur = cur + step;
      end
   endtask

   // Queries with the odd stray load mixed in
   task automatic run_queries(int k);
      int j;
      for (j = 0; j < k; j++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(nses_pkg::REQ_LOAD, IDX_W'($urandom_range(0, DEPTH - 1)),
                      rand_bits48());
         else
            send_item(nses_pkg::REQ_QUERY, IDX_W'($urandom), pick_query());
      end
   endtask

   // Response side: random ready bursts and gaps, long hold-offs on request
   initial begin : rsp_side
      int on_len, off_len;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_offs < hold_offs_asked) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_offs++;
         end
         on_len = quiet ? 50 : $urandom_range(1, 30);
         rsp_ch.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         off_len = pick_gap();
         if (off_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int n, r, k, phase, start_items;
      logic [CSR_DATA_W-1:0] cnt_word, tol_word;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = nses_pkg::REQ_LOAD;
      req_ch.entry_index = '0;
      req_ch.value       = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = nses_pkg::CSR_ENTRY_COUNT;
      csr_ch.data        = '0;
      for (n = 0; n < DEPTH; n++) shadow_table[n] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty and single-entry tables report the size error
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(VAL_MAX));
      program_regs(48'd1, 48'd0, 1'b0);
      send_item(nses_pkg::REQ_QUERY, '1, VAL_W'(VAL_MIN));

      // Ascending table over the full range, widest tolerance
      send_item(nses_pkg::REQ_LOAD, IDX_W'(0), VAL_W'(VAL_MIN));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(1), VAL_W'(-65536));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(2), VAL_W'(65536));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(3), VAL_W'(VAL_MAX));
      program_regs(48'd4, ALL_ONES, 1'b0);
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(VAL_MIN));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(VAL_MAX));
      // midway between two entries: tie goes to the lower index
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(0));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(1));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(-(64'sd1 <<< 46)));

      // Zero tolerance accepts exact hits only; also poke an unused register
      program_regs(48'd4, 48'd0, 1'b1);
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(1));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(65536));

      // Flat table at the top of the range, query from the bottom
      send_item(nses_pkg::REQ_LOAD, IDX_W'(0), VAL_W'(VAL_MAX));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(1), VAL_W'(VAL_MAX));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(2), VAL_W'(VAL_MAX));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(3), VAL_W'(VAL_MAX));
      program_regs(48'd4, ALL_ONES, 1'b0);
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(VAL_MIN));

      // Descending table
      send_item(nses_pkg::REQ_LOAD, IDX_W'(0), VAL_W'(VAL_MAX));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(1), VAL_W'(65536));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(2), VAL_W'(-65536));
      send_item(nses_pkg::REQ_LOAD, IDX_W'(3), VAL_W'(VAL_MIN));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(-1));
      send_item(nses_pkg::REQ_QUERY, '0, VAL_W'(VAL_MAX - 5));

      // Fill the whole table, then search at, past and just over full depth
      program_regs(CSR_DATA_W'(DEPTH), 48'(rand_upto(64'sd1 <<< 40)), 1'b0);
      fill_table(DEPTH, 1'($urandom_range(0, 1)), 1);
      run_queries(25);
      cnt_word = rand_bits48();
      cnt_word[CNT_W-1:0] = '1;
      program_regs(cnt_word, ALL_ONES, 1'b1);
      run_queries(10);
      program_regs(CSR_DATA_W'(DEPTH + 1), rand_bits48(), 1'b0);
      run_queries(8);

      // Random phases: new setting, often a fresh monotonic prefix, queries
      start_items = loads_sent + queries_sent;
      phase = 0;
      while (loads_sent + queries_sent - start_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 65) n = $urandom_range(2, 40);
         else if (r < 80) n = $urandom_range(41, 300);
         else if (r < 90) n = $urandom_range(0, 1);
         else n = $urandom_range(301, 2047);
         case ($urandom_range(0, 4))
            0: tol_word = '0;
            1: tol_word = ALL_ONES;
            2: tol_word = rand_bits48();
            default: tol_word = 48'(rand_upto(1048576));
         endcase
         if ($urandom_range(0, 3) == 0) cnt_word = rand_bits48();
         else cnt_word = '0;
         cnt_word[CNT_W-1:0] = CNT_W'(n);
         program_regs(cnt_word, tol_word, $urandom_range(0, 7) == 0);
         quiet = ($urandom_range(0, 5) == 0);
         if (n >= 2 && n <= 64 && $urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 5);
            fill_table(n, 1'($urandom_range(0, 1)), (r < 4) ? 0 : r - 3);
         end
         k = $urandom_range(8, 30);
         // hold the response side off while requests keep coming
         if (phase == 1) begin
            hold_offs_asked++;
            k = 40;
         end
         run_queries(k);
         phase++;
      end
      quiet = 1'b0;

      // Drain, settle and report
      wait_idle();
      $display("Covered %0d loads and %0d queries over %0d register settings, %0d hold-offs",
               loads_sent, queries_sent, settings_made, hold_offs);
      $display("Responses: %0d found, %0d beyond tolerance, %0d too few entries",
               found_count, far_count, small_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/nses_pkg.sv
hw/rtl/nses_if.sv
hw/rtl/nses_table.sv
hw/rtl/nses_search.sv
hw/rtl/nearest_sorted_entry_search.sv
tb/sv/nearest_match_checker.sv
tb/sv/nearest_sorted_entry_search_tb.sv
